/* sv/gcoc_pkg.sv */
// Shared types and constants for the grid cell outline classifier.
// Used by the configuration, classification, accumulation and top-level modules.
package gcoc_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned CountW   = 21;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned LvlCntW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MaxCols  = 1024;
  localparam int unsigned MaxRows  = 1024;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLevelCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLevel0     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLevelLast  = 3'd6;

  localparam logic [CodeW-1:0]  CodeFull    = 4'd15;
  localparam logic [CodeW-1:0]  CodeSaddleA = 4'd5;
  localparam logic [CodeW-1:0]  CodeSaddleB = 4'd10;
  localparam logic [CountW-1:0] CountMax    = {CountW{1'b1}};

  localparam logic [IdxW-1:0] LowColInit = IdxW'(MaxCols - 1);
  localparam logic [IdxW-1:0] LowRowInit = IdxW'(MaxRows - 1);

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             active;
    logic             saddle;
  } cell_class_t;

  typedef struct packed {
    logic [CountW-1:0] boxes;
    idx_t              min_col;
    idx_t              max_col;
    idx_t              min_row;
    idx_t              max_row;
  } summary_t;

endpackage

/* sv/gcoc_cfg_regs.sv */
// Configuration registers: level count and level values.
// Depends on gcoc_pkg.
module gcoc_cfg_regs #(
  parameter int unsigned MAX_LEVELS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gcoc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gcoc_pkg::ValW-1:0]      cfg_wdata_i,
  output gcoc_pkg::val_t                 levels_o [MAX_LEVELS],
  output logic [MAX_LEVELS-1:0]          level_en_o
);
  import gcoc_pkg::*;

  logic [LvlCntW-1:0] level_count_q;
  val_t               levels_q [MAX_LEVELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        levels_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegLevelCount) begin
        level_count_q <= cfg_wdata_i[LvlCntW-1:0];
      end
      for (int k = 0; k < MAX_LEVELS; k++) begin
        if (cfg_idx_i == RegLevel0 + CfgIdxW'(k) && cfg_idx_i <= RegLevelLast) begin
          levels_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  // A count above the number of level slots uses every slot.
  always_comb begin
    for (int k = 0; k < MAX_LEVELS; k++) begin
      levels_o[k]   = levels_q[k];
      level_en_o[k] = (LvlCntW'(k) < level_count_q);
    end
  end

endmodule

/* sv/gcoc_classify.sv */
// Corner match code of one cell against the enabled levels.
// Depends on gcoc_pkg.
module gcoc_classify #(
  parameter int unsigned MAX_LEVELS = 6
) (
  input  gcoc_pkg::val_t          corners_i [4],
  input  logic                    cell_valid_i,
  input  gcoc_pkg::val_t          levels_i [MAX_LEVELS],
  input  logic [MAX_LEVELS-1:0]   level_en_i,
  output gcoc_pkg::cell_class_t   class_o
);
  import gcoc_pkg::*;

  logic [CodeW-1:0] hit;
  logic [CodeW-1:0] code;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hit[c] = 1'b0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        hit[c] = hit[c] | (level_en_i[k] && corners_i[c] == levels_i[k]);
      end
    end
    code = (!cell_valid_i || hit == CodeFull) ? '0 : hit;
    class_o.code   = code;
    class_o.active = (code != '0);
    class_o.saddle = (code == CodeSaddleA) || (code == CodeSaddleB);
  end

endmodule

/* sv/gcoc_accum.sv */
// Running box count and bounding box of active cells, with the grid summary.
// Depends on gcoc_pkg.
module gcoc_accum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  first_i,
  input  logic                  last_i,
  input  gcoc_pkg::cell_class_t class_i,
  input  gcoc_pkg::idx_t        col_i,
  input  gcoc_pkg::idx_t        row_i,
  output gcoc_pkg::summary_t    summary_o
);
  import gcoc_pkg::*;

  summary_t          run_q, run_d, base;
  logic [CountW:0]   sum;

  always_comb begin
    if (first_i) begin
      base.boxes   = '0;
      base.min_col = LowColInit;
      base.max_col = '0;
      base.min_row = LowRowInit;
      base.max_row = '0;
    end else begin
      base = run_q;
    end

    sum   = {1'b0, base.boxes} + (class_i.saddle ? (CountW+1)'(2) : (CountW+1)'(1));
    run_d = base;
    if (class_i.active) begin
      run_d.boxes = (sum > {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
      if (col_i < base.min_col) run_d.min_col = col_i;
      if (col_i > base.max_col) run_d.max_col = col_i;
      if (row_i < base.min_row) run_d.min_row = row_i;
      if (row_i > base.max_row) run_d.max_row = row_i;
    end

    // Zero unless last_i and a cell was active; it includes this cell.
    summary_o = (last_i && run_d.boxes != '0) ? run_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q.boxes   <= '0;
      run_q.min_col <= LowColInit;
      run_q.max_col <= '0;
      run_q.min_row <= LowRowInit;
      run_q.max_row <= '0;
    end else if (en_i) begin
      run_q <= run_d;
    end
  end

endmodule

/* sv/grid_cell_outline_classifier_top.sv */
// Grid cell outline classifier: one cell request in, one result out, in every cycle while the sink is ready.
// Depends on gcoc_pkg, gcoc_cfg_regs, gcoc_classify and gcoc_accum.

// A cell is taken into an input register. From there it is classified and
// folded into the running count and bounds, and its result is written to an
// output register once that register is empty or the sink takes its result.
// With a ready sink a new cell can be accepted in every cycle. While a result
// waits for the sink, the input register still takes one more cell, and then
// the input stalls until the sink takes the waiting result. The running count
// and bounding box update as each cell moves to the output register. The user
// must write levels through the configuration port only while no cell is in
// flight; the block does not enforce this.
module grid_cell_outline_classifier_top #(
  parameter int unsigned MAX_LEVELS = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // corner_bottom_left, corner_bottom_right, corner_top_right, corner_top_left,
  // cell_col, cell_row, zero fill
  input  logic [151:0] s_axis_tdata,
  // cell_valid, first_cell
  input  logic [1:0]   s_axis_tuser,
  // last_cell
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cell_code, active_boxes, min_col, max_col, min_row, max_row, zero fill
  output logic [71:0]  m_axis_tdata,
  // cell_invalid
  output logic         m_axis_tuser,
  // summary_valid
  output logic         m_axis_tlast
);
  import gcoc_pkg::*;

  logic              in_vq;
  val_t              corners_q [4];
  logic              valid_q, first_q, last_q;
  idx_t              col_q, row_q;

  logic              out_vq;
  logic [CodeW-1:0]  code_q;
  logic              invalid_q, sum_valid_q;
  summary_t          summary_q;

  logic              advance, in_take;
  val_t              levels [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] level_en;
  cell_class_t       cls;
  summary_t          summary;

  assign advance       = in_vq && (!out_vq || m_axis_tready);
  assign s_axis_tready = !in_vq || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  gcoc_cfg_regs #(.MAX_LEVELS(MAX_LEVELS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .levels_o    (levels),
    .level_en_o  (level_en)
  );

  gcoc_classify #(.MAX_LEVELS(MAX_LEVELS)) u_classify (
    .corners_i    (corners_q),
    .cell_valid_i (valid_q),
    .levels_i     (levels),
    .level_en_i   (level_en),
    .class_o      (cls)
  );

  gcoc_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .first_i   (first_q),
    .last_i    (last_q),
    .class_i   (cls),
    .col_i     (col_q),
    .row_i     (row_q),
    .summary_o (summary)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (in_take) begin
        in_vq <= 1'b1;
      end else if (advance) begin
        in_vq <= 1'b0;
      end
      if (advance) begin
        out_vq <= 1'b1;
      end else if (m_axis_tready) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      corners_q[0] <= s_axis_tdata[31:0];
      corners_q[1] <= s_axis_tdata[63:32];
      corners_q[2] <= s_axis_tdata[95:64];
      corners_q[3] <= s_axis_tdata[127:96];
      col_q        <= s_axis_tdata[137:128];
      row_q        <= s_axis_tdata[147:138];
      valid_q      <= s_axis_tuser[0];
      first_q      <= s_axis_tuser[1];
      last_q       <= s_axis_tlast;
    end
    if (advance) begin
      code_q      <= cls.code;
      invalid_q   <= !valid_q;
      sum_valid_q <= last_q;
      summary_q   <= summary;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = {7'd0, summary_q.max_row, summary_q.min_row, summary_q.max_col,
                          summary_q.min_col, summary_q.boxes, code_q};
  assign m_axis_tuser  = invalid_q;
  assign m_axis_tlast  = sum_valid_q;

endmodule

/* dv/grid_cell_outline_classifier_top_test.sv */
// Self-checking testbench for grid_cell_outline_classifier_top: directed and random
// cell streams are checked against an in-file predictor of codes, counts and bounds.
// Depends on gcoc_pkg and the RTL of the block only.
module grid_cell_outline_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gcoc_pkg::*;

  localparam int unsigned NumLevels     = 6;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned MaxPrinted    = 100;
  localparam logic [CfgIdxW-1:0] RegOutOfRange = RegLevelLast + 3'd1;
  localparam val_t ValMin = 32'sh8000_0000;
  localparam val_t ValMax = 32'sh7fff_ffff;

  typedef struct packed {
    val_t bl;
    val_t br;
    val_t tr;
    val_t tl;
    logic valid;
    idx_t col;
    idx_t row;
    logic first_cell;
    logic last_cell;
  } grid_cell_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic              invalid;
    logic              summary;
    logic [CountW-1:0] boxes;
    idx_t              min_col;
    idx_t              max_col;
    idx_t              min_row;
    idx_t              max_row;
  } cell_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic [151:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tready = 1'b0;
  wire          s_axis_tready;
  wire          m_axis_tvalid;
  wire  [71:0]  m_axis_tdata;
  wire          m_axis_tuser;
  wire          m_axis_tlast;

  grid_cell_outline_classifier_top #(
    .MAX_LEVELS(NumLevels)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the configuration and the running grid state.
  logic [LvlCntW-1:0] lvl_count = '0;
  val_t               lvl_val [NumLevels] = '{default: '0};
  val_t               staged_lvl [NumLevels];
  logic [CountW-1:0]  run_boxes = '0;
  idx_t               run_low_col = LowColInit;
  idx_t               run_high_col = '0;
  idx_t               run_low_row = LowRowInit;
  idx_t               run_high_row = '0;

  grid_cell_t   cell_q[$];
  cell_result_t result_q[$];
  grid_cell_t   cell_on_bus;
  cell_result_t pred_result;
  cell_result_t want_result;
  cell_result_t seen_result;
  int unsigned  queued_n = 0;
  int unsigned  accepted_n = 0;
  int unsigned  checked_n = 0;
  int unsigned  mismatches = 0;
  int unsigned  send_gap = 0;
  int unsigned  sink_wait = 0;
  int unsigned  idle_cycles = 0;
  bit           no_idle = 1'b0;
  bit           hold_cells = 1'b0;

  function automatic logic level_hit(val_t v, int unsigned used);
    for (int k = 0; k < used; k++) begin
      if (lvl_val[k] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic fold_cell(input grid_cell_t c, output cell_result_t r);
    logic [CodeW-1:0]  code;
    logic [CountW:0]   sum;
    int unsigned       used;
    used = (lvl_count > NumLevels) ? NumLevels : lvl_count;
    code = '0;
    if (c.first_cell) begin
      run_boxes    = '0;
      run_low_col  = LowColInit;
      run_high_col = '0;
      run_low_row  = LowRowInit;
      run_high_row = '0;
    end
    if (c.valid) begin
      if (level_hit(c.bl, used)) code[0] = 1'b1;
      if (level_hit(c.br, used)) code[1] = 1'b1;
      if (level_hit(c.tr, used)) code[2] = 1'b1;
      if (level_hit(c.tl, used)) code[3] = 1'b1;
      if (code == CodeFull) code = '0;
      if (code != '0) begin
        sum = {1'b0, run_boxes} +
              ((code == CodeSaddleA || code == CodeSaddleB) ? 22'd2 : 22'd1);
        run_boxes = (sum > {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
        if (c.col < run_low_col)  run_low_col  = c.col;
        if (c.col > run_high_col) run_high_col = c.col;
        if (c.row < run_low_row)  run_low_row  = c.row;
        if (c.row > run_high_row) run_high_row = c.row;
      end
    end
    r = '0;
    r.code    = code;
    r.invalid = ~c.valid;
    r.summary = c.last_cell;
    // Bounds are only reported once at least one cell of the grid was active.
    if (c.last_cell && run_boxes != '0) begin
      r.boxes   = run_boxes;
      r.min_col = run_low_col;
      r.max_col = run_high_col;
      r.min_row = run_low_row;
      r.max_row = run_high_row;
    end
  endtask

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Driver: presents queued cells and predicts each one as its request is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      s_axis_tlast  <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        fold_cell(cell_on_bus, pred_result);
        result_q.push_back(pred_result);
        accepted_n++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!hold_cells && cell_q.size() > 0) begin
          cell_on_bus = cell_q.pop_front();
          s_axis_tdata <= {4'b0, cell_on_bus.row, cell_on_bus.col, cell_on_bus.tl,
                           cell_on_bus.tr, cell_on_bus.br, cell_on_bus.bl};
          s_axis_tuser  <= {cell_on_bus.first_cell, cell_on_bus.valid};
          s_axis_tlast  <= cell_on_bus.last_cell;
          s_axis_tvalid <= 1'b1;
          send_gap = draw_wait();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxPrinted)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: takes results with random back-pressure and checks them in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_n++;
        seen_result.code    = m_axis_tdata[3:0];
        seen_result.boxes   = m_axis_tdata[24:4];
        seen_result.min_col = m_axis_tdata[34:25];
        seen_result.max_col = m_axis_tdata[44:35];
        seen_result.min_row = m_axis_tdata[54:45];
        seen_result.max_row = m_axis_tdata[64:55];
        seen_result.invalid = m_axis_tuser;
        seen_result.summary = m_axis_tlast;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxPrinted)
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     seen_result);
        end else begin
          want_result = result_q.pop_front();
          compare_field("cell_code", want_result.code, seen_result.code);
          compare_field("cell_invalid", want_result.invalid, seen_result.invalid);
          compare_field("summary_valid", want_result.summary, seen_result.summary);
          compare_field("active_boxes", want_result.boxes, seen_result.boxes);
          compare_field("min_col", want_result.min_col, seen_result.min_col);
          compare_field("max_col", want_result.max_col, seen_result.max_col);
          compare_field("min_row", want_result.min_row, seen_result.min_row);
          compare_field("max_row", want_result.max_row, seen_result.max_row);
        end
        sink_wait = draw_wait();
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic grid_cell_t mk_cell(val_t bl, val_t br, val_t tr, val_t tl,
                                         logic valid, idx_t col, idx_t row,
                                         logic first_cell, logic last_cell);
    grid_cell_t c;
    c.bl = bl;
    c.br = br;
    c.tr = tr;
    c.tl = tl;
    c.valid = valid;
    c.col = col;
    c.row = row;
    c.first_cell = first_cell;
    c.last_cell = last_cell;
    return c;
  endfunction

  task automatic queue_cell(grid_cell_t c);
    cell_q.push_back(c);
    queued_n++;
  endtask

  task automatic drain_results();
    while (queued_n != checked_n) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == RegLevelCount)
      lvl_count = data[LvlCntW-1:0];
    else if (idx >= RegLevel0 && idx <= RegLevelLast)
      lvl_val[idx - RegLevel0] = data;
  endtask

  // Writes the level count and all six levels from staged_lvl, plus one stray
  // write past the last register, which must leave everything unchanged.
  task automatic apply_levels(logic [31:0] count_word);
    drain_results();
    write_reg(RegOutOfRange, $urandom);
    for (int k = 0; k < NumLevels; k++)
      write_reg(RegLevel0 + CfgIdxW'(k), staged_lvl[k]);
    write_reg(RegLevelCount, count_word);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  function automatic val_t pick_corner();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return lvl_val[$urandom_range(0, NumLevels - 1)];
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0: return ValMin;
        1: return ValMax;
        2: return '0;
        default: return -32'sd1;
      endcase
    end
    return val_t'($urandom);
  endfunction

  // Queues one grid in scan order from a random origin; a broken grid has its
  // first and last flags scattered at random instead.
  task automatic queue_grid(int unsigned n, bit well_formed);
    int unsigned c0, r0, w;
    logic f, l;
    c0 = $urandom_range(0, 1023);
    r0 = $urandom_range(0, 1023);
    w  = $urandom_range(1, 8);
    for (int unsigned i = 0; i < n; i++) begin
      f = well_formed ? (i == 0) : ($urandom_range(0, 3) == 0);
      l = well_formed ? (i == n - 1) : ($urandom_range(0, 3) == 0);
      queue_cell(mk_cell(pick_corner(), pick_corner(), pick_corner(), pick_corner(),
                         $urandom_range(0, 7) != 0, idx_t'(c0 + i % w),
                         idx_t'(r0 + i / w), f, l));
    end
  endtask

  initial begin
    int unsigned n, phase_items;
    bit paused;
    logic [LvlCntW-1:0] phase_count [6];
    phase_count = '{3'd6, 3'd7, 3'd1, 3'd0, 3'd3, 3'd5};
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset no level is in use, so zero corners match nothing.
    queue_cell(mk_cell(0, 0, 0, 0, 1, 10'd3, 10'd3, 1, 1));

    staged_lvl = '{ValMin, ValMax, 32'sd0, -32'sd1, 32'sd5, 32'sd77};
    apply_levels(32'd4);
    queue_cell(mk_cell(ValMin, ValMin, ValMin, ValMin, 1, 10'd5, 10'd5, 1, 0));
    queue_cell(mk_cell(ValMin, 123, 123, 123, 1, 10'd0, 10'd1023, 0, 0));
    queue_cell(mk_cell(ValMax, 3, 0, 4, 1, 10'd1023, 10'd0, 0, 0));
    queue_cell(mk_cell(1, -1, 2, 0, 1, 10'd512, 10'd511, 0, 0));
    queue_cell(mk_cell(-1, -1, ValMax, -1, 0, 10'd700, 10'd700, 0, 0));
    queue_cell(mk_cell(5, 77, 5, 77, 1, 10'd800, 10'd800, 0, 0));
    queue_cell(mk_cell(9, 9, ValMax, ValMin, 1, 10'd6, 10'd7, 0, 1));
    // Without a first cell the next grid keeps adding to the old totals.
    queue_cell(mk_cell(9, 9, 9, 0, 1, 10'd100, 10'd200, 0, 1));
    queue_cell(mk_cell(9, 9, 9, 9, 1, 10'd100, 10'd200, 1, 0));
    queue_cell(mk_cell(0, 0, 0, 0, 0, 10'd101, 10'd200, 0, 1));
    queue_cell(mk_cell(9, ValMax, 9, 9, 1, 10'd1023, 10'd1023, 1, 1));

    // A level count above the maximum is clipped; two levels are the same.
    staged_lvl = '{32'sd1000, 32'sd1000, 32'sd11, 32'sd12, 32'sd13, 32'sd77};
    apply_levels({29'h1234567, 3'd7});
    queue_cell(mk_cell(1000, 77, 1, 2, 1, 10'd40, 10'd41, 1, 0));
    queue_cell(mk_cell(77, 1000, 77, 1000, 1, 10'd42, 10'd43, 0, 1));
    queue_cell(mk_cell(77, 1000, 77, 1000, 1, 10'd42, 10'd43, 1, 1));
    apply_levels(32'd0);
    queue_cell(mk_cell(1000, 77, 11, 12, 1, 10'd44, 10'd45, 1, 1));

    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < NumLevels; k++) staged_lvl[k] = val_t'($urandom);
      if (p == 4) begin
        staged_lvl[0] = ValMin;
        staged_lvl[1] = ValMax;
      end
      if (p == 5) staged_lvl[2] = staged_lvl[1];
      apply_levels({$urandom_range(0, 1) ? 29'(0) : 29'($urandom), phase_count[p]});
      phase_items = 0;
      while (phase_items < 250) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        no_idle = ($urandom_range(0, 4) == 0);
        queue_grid(n, $urandom_range(0, 4) != 0);
        phase_items += n;
        if (p == 2 && !paused && phase_items > 100) begin
          // Stop sending until every outstanding result has come back.
          paused = 1'b1;
          hold_cells = 1'b1;
          @(posedge clk_i);
          while (s_axis_tvalid || accepted_n != checked_n) @(posedge clk_i);
          hold_cells = 1'b0;
        end
        while (cell_q.size() > 64) @(posedge clk_i);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/gcoc_pkg.sv
sv/gcoc_cfg_regs.sv
sv/gcoc_classify.sv
sv/gcoc_accum.sv
sv/grid_cell_outline_classifier_top.sv
dv/grid_cell_outline_classifier_top_test.sv
